// File: sv/assert_macros.svh
// Assertion macros shared by the burst energy detector RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define BED_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define BED_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: sv/bed_pkg.sv
// Types and constants of the burst energy detector.
// No dependencies; used by bed_divider and burst_energy_detector.
package bed_pkg;

   localparam int unsigned MIN_WINDOW   = 128;
   localparam int unsigned WINDOW_SCALE = 1000;

   localparam logic [31:0] MIN_WINDOW_CNT = 32'(MIN_WINDOW);
   localparam logic [31:0] WINDOW_SPAN    = 32'(WINDOW_SCALE * MIN_WINDOW);

   localparam int unsigned DIVIDEND_W = 58;
   localparam int unsigned DIVISOR_W  = 32;
   localparam int unsigned QCOUNT_W   = $clog2(DIVIDEND_W + 1);

   localparam int unsigned CSR_W       = 16;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [15:0] SIGMA_RESET = 16'd1024;
   localparam logic [15:0] POS_RESET   = 16'd4;
   localparam logic [15:0] NEG_RESET   = 16'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_SIGMA = 2'd0,
      CSR_POS_REQUIRED  = 2'd1,
      CSR_NEG_REQUIRED  = 2'd2
   } bed_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_START,
      ST_MUL,
      ST_NUM,
      ST_MAG,
      ST_DIV,
      ST_TRIG,
      ST_TLVL
   } bed_state_type;

   typedef enum logic [1:0] {
      CH_I,
      CH_Q,
      CH_NOISE
   } bed_chan_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } bed_div_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } bed_div_sts_type;

endpackage

// File: sv/bed_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bed_pkg for widths and the control and status structs.
module bed_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  bed_pkg::bed_div_ctrl_type div_ctrl,
   output bed_pkg::bed_div_sts_type  div_sts
);
   import bed_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;
   logic                  fit;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor_ff};
      fit     = ~trial[DIVISOR_W+1];

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (div_ctrl.start) begin
         busy_in    = 1'b1;
         count_in   = QCOUNT_W'(DIVIDEND_W);
         rem_in     = '0;
         quo_in     = div_ctrl.dividend;
         divisor_in = div_ctrl.divisor;
      end else if (busy_ff) begin
         rem_in   = fit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fit};
         count_in = count_ff - QCOUNT_W'(1);
         if (count_ff == QCOUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

// File: sv/burst_energy_detector.sv
// Burst energy detector with adaptive DC offset and noise floor (top level).
// Depends on bed_pkg, bed_divider and assert_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   req     | in        | req_valid / req_ready  | sample_i, sample_q, end_of_block
//   rsp     | out       | rsp_valid / rsp_ready  | clean_i, clean_q, power, in_frame,
//           |           |                        | frame_start, frame_end
//   csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// The accept cycle removes the offset and registers the word; the evaluation
// state then forms the power, runs the frame state machine and loads the output
// register. A word that closes the window adds the START, TRIG and TLVL states;
// a full window also runs three blends between START and TRIG, which share one
// multiplier and the 58-bit divider, which yields one quotient bit per cycle.
// req_ready is low meanwhile. A held output word stalls the evaluation cycle only.
// Reset is synchronous and needs no clearing pass.

`include "assert_macros.svh"

module burst_energy_detector (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [7:0]                req_sample_i,
   input  logic signed [7:0]                req_sample_q,
   input  logic                             req_end_of_block,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [7:0]                rsp_clean_i,
   output logic signed [7:0]                rsp_clean_q,
   output logic [15:0]                      rsp_power,
   output logic                             rsp_in_frame,
   output logic                             rsp_frame_start,
   output logic                             rsp_frame_end,

   input  logic                             csr_we,
   input  logic [bed_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bed_pkg::CSR_W-1:0]        csr_wdata
);
   import bed_pkg::*;

   // Offset truncated toward zero to an integer sample value.
   function automatic logic signed [8:0] trunc_offset(input logic [15:0] off);
      logic signed [8:0] floor_val;
      logic              round_up;
      floor_val = {off[15], off[15:8]};
      round_up  = off[15] & (|off[7:0]);
      return floor_val + $signed({8'b0, round_up});
   endfunction

   // Sequencer and configuration.
   bed_state_type state_ff, state_in;
   bed_chan_type  chan_ff, chan_in;
   logic [15:0]   sigma_ff, sigma_in;
   logic [15:0]   pos_ff, pos_in;
   logic [15:0]   neg_ff, neg_in;

   // Detector state.
   logic          mode_ff, mode_in;
   logic [15:0]   loud_ff, loud_in;
   logic [15:0]   quiet_ff, quiet_in;
   logic [15:0]   offset_i_ff, offset_i_in;
   logic [15:0]   offset_q_ff, offset_q_in;
   logic [23:0]   noise_ff, noise_in;
   logic [24:0]   trig_ff, trig_in;
   logic [39:0]   sum_i_ff, sum_i_in;
   logic [39:0]   sum_q_ff, sum_q_in;
   logic [47:0]   energy_ff, energy_in;
   logic [31:0]   window_count_ff, window_count_in;

   // Word held between the accept and evaluation cycles.
   logic signed [7:0] clean_i_ff, clean_i_in;
   logic signed [7:0] clean_q_ff, clean_q_in;
   logic [7:0]        sample_i_ff, sample_i_in;
   logic [7:0]        sample_q_ff, sample_q_in;
   logic              eob_ff, eob_in;

   // Blend datapath registers.
   logic [31:0]         m_ff, m_in;
   logic [31:0]         diff_ff, diff_in;
   logic signed [57:0]  prod_ff, prod_in;
   logic signed [57:0]  num_ff, num_in;
   logic                neg_sign_ff, neg_sign_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rsp_clean_i_ff, rsp_clean_i_in;
   logic signed [7:0] rsp_clean_q_ff, rsp_clean_q_in;
   logic [15:0]       rsp_power_ff, rsp_power_in;
   logic              rsp_in_frame_ff, rsp_in_frame_in;
   logic              rsp_frame_start_ff, rsp_frame_start_in;
   logic              rsp_frame_end_ff, rsp_frame_end_in;

   // Control decoded from the state.
   logic accept;
   logic eval_go;
   logic close_now;
   logic long_window;

   // Shared multiplier and divider.
   logic signed [24:0] mul_a;
   logic [31:0]        mul_b;
   bed_div_ctrl_type   div_ctrl;
   bed_div_sts_type    div_sts;

   // Combinational helpers.
   logic signed [8:0]  diff_i, diff_q;
   logic signed [15:0] sq_i, sq_q;
   logic [15:0]        pw;
   logic               loud;
   logic [15:0]        loud_inc, quiet_inc;
   logic               start_flag, stop_flag;
   logic signed [57:0] addend;
   logic [57:0]        half;
   logic [57:0]        mag;
   logic [57:0]        quot;
   logic [15:0]        off_sat;
   logic [23:0]        noise_sat;

   bed_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .div_sts  (div_sts)
   );

   // ---------------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_EVAL;
         ST_EVAL:  if (eval_go) state_in = close_now ? ST_START : ST_IDLE;
         ST_START: state_in = long_window ? ST_MUL : ST_TRIG;
         ST_MUL:   state_in = ST_NUM;
         ST_NUM:   state_in = ST_MAG;
         ST_MAG:   state_in = ST_DIV;
         ST_DIV: begin
            if (div_sts.done) state_in = (chan_ff == CH_NOISE) ? ST_TRIG : ST_MUL;
         end
         ST_TRIG:  state_in = ST_TLVL;
         ST_TLVL:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer outputs. The evaluation cycle waits only while the output
   // register still holds a word that is not being taken.
   // ---------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      eval_go   = 1'b0;
      mul_a     = {1'b0, noise_ff};
      mul_b     = {16'b0, sigma_ff};
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EVAL: eval_go   = ~rsp_valid_ff | rsp_ready;
         ST_MUL: begin
            mul_b = diff_ff;
            case (chan_ff)
               CH_I:    mul_a = {{9{offset_i_ff[15]}}, offset_i_ff};
               CH_Q:    mul_a = {{9{offset_q_ff[15]}}, offset_q_ff};
               default: mul_a = {1'b0, noise_ff};
            endcase
         end
         default: ;
      endcase
   end

   assign accept = req_valid & req_ready;

   // The one multiplier of the blend path: numerator terms and the trigger level.
   assign prod_in = mul_a * $signed({1'b0, mul_b});

   // ---------------------------------------------------------------------------
   // Datapath.
   // ---------------------------------------------------------------------------
   always_comb begin
      // Offset removal for the word being accepted.
      diff_i     = $signed({req_sample_i[7], req_sample_i}) - trunc_offset(offset_i_ff);
      diff_q     = $signed({req_sample_q[7], req_sample_q}) - trunc_offset(offset_q_ff);
      clean_i_in = accept ? diff_i[7:0] : clean_i_ff;
      clean_q_in = accept ? diff_q[7:0] : clean_q_ff;
      sample_i_in = accept ? req_sample_i : sample_i_ff;
      sample_q_in = accept ? req_sample_q : sample_q_ff;
      eob_in      = accept ? req_end_of_block : eob_ff;

      // Power and run counting for the held word.
      sq_i      = clean_i_ff * clean_i_ff;
      sq_q      = clean_q_ff * clean_q_ff;
      pw        = $unsigned(sq_i) + $unsigned(sq_q);
      loud      = {9'b0, pw} >= trig_ff;
      loud_inc  = (loud_ff == 16'hFFFF) ? loud_ff : loud_ff + 16'd1;
      quiet_inc = (quiet_ff == 16'hFFFF) ? quiet_ff : quiet_ff + 16'd1;

      mode_in         = mode_ff;
      loud_in         = loud_ff;
      quiet_in        = quiet_ff;
      start_flag      = 1'b0;
      stop_flag       = 1'b0;
      offset_i_in     = offset_i_ff;
      offset_q_in     = offset_q_ff;
      noise_in        = noise_ff;
      trig_in         = trig_ff;
      sum_i_in        = sum_i_ff;
      sum_q_in        = sum_q_ff;
      energy_in       = energy_ff;
      window_count_in = window_count_ff;
      chan_in         = chan_ff;
      m_in            = m_ff;
      diff_in         = diff_ff;
      num_in          = num_ff;
      neg_sign_in     = neg_sign_ff;

      rsp_clean_i_in     = rsp_clean_i_ff;
      rsp_clean_q_in     = rsp_clean_q_ff;
      rsp_power_in       = rsp_power_ff;
      rsp_in_frame_in    = rsp_in_frame_ff;
      rsp_frame_start_in = rsp_frame_start_ff;
      rsp_frame_end_in   = rsp_frame_end_ff;
      rsp_valid_in       = rsp_ready ? 1'b0 : rsp_valid_ff;

      // Seek and in-frame decisions. A run length of zero behaves as one
      // because the incremented run is never below one.
      if (!mode_ff) begin
         if (loud) begin
            if (loud_inc >= pos_ff) start_flag = 1'b1;
         end
      end else begin
         if (!loud) begin
            if (quiet_inc >= neg_ff) stop_flag = 1'b1;
         end
      end
      close_now = eob_ff | stop_flag;

      if (eval_go) begin
         if (!mode_ff) begin
            if (loud) begin
               loud_in = loud_inc;
               if (start_flag) begin
                  mode_in  = 1'b1;
                  quiet_in = '0;
               end
            end else begin
               loud_in = '0;
            end
         end else begin
            if (!loud) begin
               quiet_in = quiet_inc;
               if (stop_flag) begin
                  mode_in  = 1'b0;
                  quiet_in = '0;
                  loud_in  = '0;
               end
            end else begin
               quiet_in = '0;
            end
         end

         sum_i_in  = sum_i_ff + {{32{sample_i_ff[7]}}, sample_i_ff};
         sum_q_in  = sum_q_ff + {{32{sample_q_ff[7]}}, sample_q_ff};
         energy_in = energy_ff + {32'b0, pw};
         if (window_count_ff != 32'hFFFF_FFFF) window_count_in = window_count_ff + 32'd1;

         rsp_valid_in       = 1'b1;
         rsp_clean_i_in     = clean_i_ff;
         rsp_clean_q_in     = clean_q_ff;
         rsp_power_in       = pw;
         rsp_in_frame_in    = mode_in;
         rsp_frame_start_in = start_flag;
         rsp_frame_end_in   = stop_flag;
      end

      // Window close: M is the larger of N and the window span.
      long_window = window_count_ff >= MIN_WINDOW_CNT;
      if (state_ff == ST_START) begin
         chan_in = CH_I;
         if (window_count_ff > WINDOW_SPAN) begin
            m_in    = window_count_ff;
            diff_in = '0;
         end else begin
            m_in    = WINDOW_SPAN;
            diff_in = WINDOW_SPAN - window_count_ff;
         end
      end

      // Numerator: weighted old value plus the window sum scaled by 256.
      case (chan_ff)
         CH_I:    addend = $signed({{10{sum_i_ff[39]}}, sum_i_ff, 8'b0});
         CH_Q:    addend = $signed({{10{sum_q_ff[39]}}, sum_q_ff, 8'b0});
         default: addend = $signed({2'b00, energy_ff, 8'b0});
      endcase
      if (state_ff == ST_NUM) num_in = prod_ff + addend;

      // Magnitude plus half the divisor gives rounding to nearest, ties away
      // from zero, once the sign is put back.
      half = {26'b0, m_ff};
      half = half >> 1;
      if (num_ff[57]) mag = half - $unsigned(num_ff);
      else            mag = $unsigned(num_ff) + half;
      if (state_ff == ST_MAG) neg_sign_in = num_ff[57];

      div_ctrl.start    = (state_ff == ST_MAG);
      div_ctrl.dividend = mag;
      div_ctrl.divisor  = m_ff;

      // Saturate the quotient and write back.
      quot = div_sts.quotient;
      if (neg_sign_ff) off_sat = (quot > 58'd32768) ? 16'h8000 : (~quot[15:0] + 16'd1);
      else             off_sat = (quot > 58'd32767) ? 16'h7FFF : quot[15:0];
      noise_sat = (quot > 58'hFF_FFFF) ? 24'hFF_FFFF : quot[23:0];

      if (state_ff == ST_DIV && div_sts.done) begin
         case (chan_ff)
            CH_I: begin
               offset_i_in = off_sat;
               chan_in     = CH_Q;
            end
            CH_Q: begin
               offset_q_in = off_sat;
               chan_in     = CH_NOISE;
            end
            default: noise_in = noise_sat;
         endcase
      end

      // New trigger level from the product of noise floor and sigma; the
      // window restarts empty.
      if (state_ff == ST_TLVL) begin
         trig_in         = {1'b0, prod_ff[39:16]} + 25'd1;
         sum_i_in        = '0;
         sum_q_in        = '0;
         energy_in       = '0;
         window_count_in = '0;
      end
   end

   // Configuration writes; an index beyond the register list is ignored.
   always_comb begin
      sigma_in = sigma_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER_SIGMA: sigma_in = csr_wdata;
            CSR_POS_REQUIRED:  pos_in   = csr_wdata;
            CSR_NEG_REQUIRED:  neg_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chan_ff         <= CH_I;
         sigma_ff        <= SIGMA_RESET;
         pos_ff          <= POS_RESET;
         neg_ff          <= NEG_RESET;
         mode_ff         <= 1'b0;
         loud_ff         <= '0;
         quiet_ff        <= '0;
         offset_i_ff     <= '0;
         offset_q_ff     <= '0;
         noise_ff        <= '0;
         trig_ff         <= 25'd1;
         sum_i_ff        <= '0;
         sum_q_ff        <= '0;
         energy_ff       <= '0;
         window_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         chan_ff         <= chan_in;
         sigma_ff        <= sigma_in;
         pos_ff          <= pos_in;
         neg_ff          <= neg_in;
         mode_ff         <= mode_in;
         loud_ff         <= loud_in;
         quiet_ff        <= quiet_in;
         offset_i_ff     <= offset_i_in;
         offset_q_ff     <= offset_q_in;
         noise_ff        <= noise_in;
         trig_ff         <= trig_in;
         sum_i_ff        <= sum_i_in;
         sum_q_ff        <= sum_q_in;
         energy_ff       <= energy_in;
         window_count_ff <= window_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clean_i_ff         <= clean_i_in;
      clean_q_ff         <= clean_q_in;
      sample_i_ff        <= sample_i_in;
      sample_q_ff        <= sample_q_in;
      eob_ff             <= eob_in;
      m_ff               <= m_in;
      diff_ff            <= diff_in;
      num_ff             <= num_in;
      neg_sign_ff        <= neg_sign_in;
      rsp_clean_i_ff     <= rsp_clean_i_in;
      rsp_clean_q_ff     <= rsp_clean_q_in;
      rsp_power_ff       <= rsp_power_in;
      rsp_in_frame_ff    <= rsp_in_frame_in;
      rsp_frame_start_ff <= rsp_frame_start_in;
      rsp_frame_end_ff   <= rsp_frame_end_in;
      if (state_ff == ST_MUL || state_ff == ST_TRIG) prod_ff <= prod_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clean_i     = rsp_clean_i_ff;
   assign rsp_clean_q     = rsp_clean_q_ff;
   assign rsp_power       = rsp_power_ff;
   assign rsp_in_frame    = rsp_in_frame_ff;
   assign rsp_frame_start = rsp_frame_start_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   `BED_ASSERT_IMP(a_div_busy_in_div, clock, reset, div_sts.busy, state_ff == ST_DIV)
   `BED_ASSERT_IMP(a_div_start_free, clock, reset, div_ctrl.start, !div_sts.busy && !div_sts.done)
   `BED_ASSERT_NXT(a_accept_to_eval, clock, reset, req_valid && req_ready, state_ff == ST_EVAL)
   `BED_ASSERT_NXT(a_window_cleared, clock, reset, state_ff == ST_TLVL, window_count_ff == '0 && energy_ff == '0)
   `BED_ASSERT_IMP(a_start_in_frame, clock, reset, rsp_valid_ff && rsp_frame_start_ff, rsp_in_frame_ff && !rsp_frame_end_ff)

endmodule
